// ===== rtl/ase_pkg.sv =====
// Shared types and constants for the Annex B SEI timestamp extractor.
package ase_pkg;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int WORD_W = 64;
  localparam int OUT_BITS = 2 + 4 * WORD_W;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_SEI = 5'd6;
  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] ESC_BYTE = 8'h03;
  localparam logic [7:0] EXT_BYTE = 8'hFF;

  localparam int PTYPE_USER_DATA = 5;
  localparam int MIN_PAYLOAD = 49;
  localparam int UUID_LEN = 16;
  localparam int WORDS_FIRST = 17;

  localparam logic [7:0] MARKER_UUID [UUID_LEN] = '{
    8'h52, 8'h50, 8'h43, 8'h2D, 8'h4C, 8'h41, 8'h54, 8'h45,
    8'h4E, 8'h43, 8'h59, 8'h2D, 8'h53, 8'h45, 8'h49, 8'h31
  };

  typedef enum logic [1:0] {
    NAL_SEARCH,
    NAL_HEADER,
    NAL_BODY
  } nal_phase_t;

  typedef enum logic [1:0] {
    SEI_TYPE,
    SEI_SIZE,
    SEI_PAYLOAD,
    SEI_SKIP
  } sei_phase_t;

  typedef struct packed {
    logic       is_start;
    logic       last;
    logic [7:0] data;
  } token_t;

endpackage

// ===== rtl/annexb_sei_timestamp_extractor.sv =====
// Top level: Annex B byte stream parser that extracts SEI marker timestamps.
//
//   channel | dir | tdata (low bit up)                          | tlast
//   s_axis  | in  | data_byte[7:0]                              | last_byte
//   m_axis  | out | found, marker_seen, frame_id, capture_ms,   | -
//           |     | encode_ms, send_ms (64 each), 6 zero pad    |
//
// One byte per cycle while s_tready is high. Zero bytes that may open a
// start code wait in an 8-entry byte queue until they are known to be
// payload; the parser takes one queued byte per cycle when one is ready,
// and registers the result as it takes the last byte. Reset empties the
// queue and clears the parser. A result stalled on m_tready holds the
// parser at the next last byte; the queue then fills and s_tready drops.
module annexb_sei_timestamp_extractor #(
  parameter int SIZE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // data_byte
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [ase_pkg::OUT_W-1:0] m_tdata    // found, marker_seen, frame_id,
                                               // capture_ms, encode_ms, send_ms
);

  localparam logic [SIZE_BITS-1:0] SUM_MAX = '1;
  localparam logic [SIZE_BITS-1:0] PTYPE_UD = SIZE_BITS'(ase_pkg::PTYPE_USER_DATA);
  localparam logic [SIZE_BITS-1:0] MIN_SIZE = SIZE_BITS'(ase_pkg::MIN_PAYLOAD);
  localparam logic [SIZE_BITS-1:0] UUID_END = SIZE_BITS'(ase_pkg::UUID_LEN);
  localparam logic [SIZE_BITS-1:0] WORDS_BEG = SIZE_BITS'(ase_pkg::WORDS_FIRST);
  localparam int CAND_W = 4 * ase_pkg::WORD_W;

  // byte queue
  ase_pkg::token_t             q [ase_pkg::QDEPTH];
  logic [ase_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ase_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ase_pkg::QCNT_W-1:0]  count;
  logic [1:0]                  held;

  logic                        acc;
  logic                        is_start;
  logic                        avail;
  logic                        pop;
  logic                        load;
  ase_pkg::token_t             head;
  ase_pkg::token_t             in_tok;
  logic [ase_pkg::QPTR_W-1:0]  wr_idx;
  logic [1:0]                  drop;

  assign s_tready = count < ase_pkg::QCNT_W'(ase_pkg::QDEPTH);
  assign acc      = s_tvalid && s_tready;
  assign is_start = (s_tdata == ase_pkg::START_BYTE) && (held >= 2'd2);
  assign drop     = is_start ? held : 2'd0;
  assign wr_idx   = wr_ptr - ase_pkg::QPTR_W'(drop);
  assign head     = q[rd_ptr];
  assign avail    = count > ase_pkg::QCNT_W'(held);
  assign pop      = avail && (!head.last || !m_tvalid || m_tready);
  assign load     = pop && head.last;

  assign in_tok.is_start = is_start;
  assign in_tok.last     = s_tlast;
  assign in_tok.data     = s_tdata;

  always_ff @(posedge clk) begin
    if (acc) begin
      q[wr_idx] <= in_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      held   <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (acc) begin
        wr_ptr <= wr_idx + 1'b1;
      end
      count <= count - ase_pkg::QCNT_W'(acc ? drop : 2'd0)
               + ase_pkg::QCNT_W'(acc) - ase_pkg::QCNT_W'(pop);
      if (acc) begin
        if (s_tlast || s_tdata != 8'h00) begin
          held <= 2'd0;
        end else if (held != 2'd3) begin
          held <= held + 2'd1;
        end
      end
    end
  end

  // parser state
  ase_pkg::nal_phase_t   nal_phase, nal_phase_next;
  logic                  nal_is_sei, nal_is_sei_next;
  logic [1:0]            esc_cnt, esc_cnt_next;
  ase_pkg::sei_phase_t   sei_phase, sei_phase_next;
  logic [SIZE_BITS-1:0]  type_sum, type_sum_next;
  logic [SIZE_BITS-1:0]  size_sum, size_sum_next;
  logic [SIZE_BITS-1:0]  pay_idx, pay_idx_next;
  logic                  uuid_ok, uuid_ok_next;
  logic [CAND_W-1:0]     cand, cand_next;
  logic [CAND_W-1:0]     committed, committed_next;
  logic                  search_done, search_done_next;

  logic [7:0]            b;
  logic [SIZE_BITS:0]    type_add;
  logic [SIZE_BITS:0]    size_add;
  logic [SIZE_BITS-1:0]  type_sat;
  logic [SIZE_BITS-1:0]  size_sat;
  logic [SIZE_BITS-1:0]  idx_inc;
  logic [4:0]            k;
  logic                  wanted;
  logic                  res_found;
  logic                  res_seen;
  logic [CAND_W-1:0]     res_words;

  assign b        = head.data;
  assign type_add = {1'b0, type_sum} + {{(SIZE_BITS-7){1'b0}}, b};
  assign size_add = {1'b0, size_sum} + {{(SIZE_BITS-7){1'b0}}, b};
  assign type_sat = type_add[SIZE_BITS] ? SUM_MAX : type_add[SIZE_BITS-1:0];
  assign size_sat = size_add[SIZE_BITS] ? SUM_MAX : size_add[SIZE_BITS-1:0];
  assign idx_inc  = pay_idx + 1'b1;
  assign k        = 5'(pay_idx - WORDS_BEG);
  assign wanted   = (type_sum == PTYPE_UD) && (size_sum >= MIN_SIZE);

  always_comb begin
    nal_phase_next   = nal_phase;
    nal_is_sei_next  = nal_is_sei;
    esc_cnt_next     = esc_cnt;
    sei_phase_next   = sei_phase;
    type_sum_next    = type_sum;
    size_sum_next    = size_sum;
    pay_idx_next     = pay_idx;
    uuid_ok_next     = uuid_ok;
    cand_next        = cand;
    committed_next   = committed;
    search_done_next = search_done;

    if (pop) begin
      if (head.is_start) begin
        nal_phase_next  = ase_pkg::NAL_HEADER;
        nal_is_sei_next = 1'b0;
      end else if (!search_done) begin
        if (nal_phase == ase_pkg::NAL_HEADER) begin
          nal_is_sei_next = (b[4:0] & ase_pkg::NAL_TYPE_MASK) == ase_pkg::NAL_TYPE_SEI;
          nal_phase_next  = ase_pkg::NAL_BODY;
          esc_cnt_next    = 2'd0;
          sei_phase_next  = ase_pkg::SEI_TYPE;
          type_sum_next   = '0;
          size_sum_next   = '0;
          pay_idx_next    = '0;
        end else if (nal_phase == ase_pkg::NAL_BODY && nal_is_sei) begin
          if (esc_cnt == 2'd2 && b == ase_pkg::ESC_BYTE) begin
            esc_cnt_next = 2'd0;
          end else begin
            if (b == 8'h00) begin
              esc_cnt_next = (esc_cnt == 2'd3) ? 2'd3 : esc_cnt + 2'd1;
            end else begin
              esc_cnt_next = 2'd0;
            end
            unique case (sei_phase)
              ase_pkg::SEI_TYPE: begin
                type_sum_next = type_sat;
                if (b != ase_pkg::EXT_BYTE) begin
                  sei_phase_next = ase_pkg::SEI_SIZE;
                end
              end
              ase_pkg::SEI_SIZE: begin
                size_sum_next = size_sat;
                if (b != ase_pkg::EXT_BYTE) begin
                  pay_idx_next = '0;
                  uuid_ok_next = 1'b1;
                  cand_next    = '0;
                  if (size_sat == SUM_MAX) begin
                    sei_phase_next = ase_pkg::SEI_SKIP;
                  end else if (size_sat == '0) begin
                    sei_phase_next = ase_pkg::SEI_TYPE;
                    type_sum_next  = '0;
                    size_sum_next  = '0;
                  end else begin
                    sei_phase_next = ase_pkg::SEI_PAYLOAD;
                  end
                end
              end
              ase_pkg::SEI_PAYLOAD: begin
                if (wanted) begin
                  if (pay_idx < UUID_END) begin
                    if (b != ase_pkg::MARKER_UUID[pay_idx[3:0]]) begin
                      uuid_ok_next = 1'b0;
                    end
                  end else if (pay_idx >= WORDS_BEG && pay_idx < MIN_SIZE) begin
                    cand_next[{k, 3'b000} +: 8] = cand[{k, 3'b000} +: 8] | b;
                  end
                end
                pay_idx_next = idx_inc;
                if (idx_inc >= size_sum) begin
                  if (wanted && uuid_ok_next) begin
                    committed_next   = cand_next;
                    search_done_next = 1'b1;
                  end
                  sei_phase_next = ase_pkg::SEI_TYPE;
                  type_sum_next  = '0;
                  size_sum_next  = '0;
                  pay_idx_next   = '0;
                end
              end
              ase_pkg::SEI_SKIP: begin
              end
            endcase
          end
        end
      end
    end

    res_seen  = search_done_next;
    res_words = committed_next;
    res_found = search_done_next && (committed_next[127:64] != '0)
                && (committed_next[191:128] != '0) && (committed_next[255:192] != '0);

    if (load) begin
      nal_phase_next   = ase_pkg::NAL_SEARCH;
      nal_is_sei_next  = 1'b0;
      esc_cnt_next     = 2'd0;
      sei_phase_next   = ase_pkg::SEI_TYPE;
      type_sum_next    = '0;
      size_sum_next    = '0;
      pay_idx_next     = '0;
      uuid_ok_next     = 1'b1;
      cand_next        = '0;
      committed_next   = '0;
      search_done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nal_phase   <= ase_pkg::NAL_SEARCH;
      nal_is_sei  <= 1'b0;
      esc_cnt     <= 2'd0;
      sei_phase   <= ase_pkg::SEI_TYPE;
      type_sum    <= '0;
      size_sum    <= '0;
      pay_idx     <= '0;
      uuid_ok     <= 1'b1;
      cand        <= '0;
      committed   <= '0;
      search_done <= 1'b0;
    end else begin
      nal_phase   <= nal_phase_next;
      nal_is_sei  <= nal_is_sei_next;
      esc_cnt     <= esc_cnt_next;
      sei_phase   <= sei_phase_next;
      type_sum    <= type_sum_next;
      size_sum    <= size_sum_next;
      pay_idx     <= pay_idx_next;
      uuid_ok     <= uuid_ok_next;
      cand        <= cand_next;
      committed   <= committed_next;
      search_done <= search_done_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{(ase_pkg::OUT_W - ase_pkg::OUT_BITS){1'b0}}, res_words,
                  res_seen, res_found};
    end
  end

endmodule

// ===== rtl/ase_checker.sv =====
// Port-level checks for the Annex B SEI timestamp extractor, with bind.
module ase_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [7:0]                s_tdata,
  input logic                      s_tlast,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [ase_pkg::OUT_W-1:0] m_tdata
);

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tlast ^ (^s_tdata);

  // queue is empty right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> s_tready)
    else $error("s_tready low after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_found_needs_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("found without marker");

  a_no_marker_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[257:2] == '0)
    else $error("words nonzero without marker");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      m_tdata[129:66] != '0 && m_tdata[193:130] != '0 && m_tdata[257:194] != '0)
    else $error("found with a zero timestamp");

endmodule

bind annexb_sei_timestamp_extractor ase_checker u_ase_checker (.*);

// ===== verif/annexb_sei_timestamp_checker.sv =====
// Scoreboard for the Annex B SEI timestamp extractor: predicts results and compares them.
module annexb_sei_timestamp_checker
  import ase_pkg::*;
#(
  parameter int SIZE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               mismatches,
  output int               awaiting
);

  localparam longint unsigned SUM_MAX = (64'd1 << SIZE_BITS) - 1;

  typedef struct packed {
    logic [63:0] send_ms;
    logic [63:0] encode_ms;
    logic [63:0] capture_ms;
    logic [63:0] frame_id;
    logic        marker_seen;
    logic        found;
  } stamp_t;

  int unsigned     zero_run;
  int unsigned     esc_zeros;
  nal_phase_t      nal_st;
  sei_phase_t      sei_st;
  bit              in_sei;
  bit              id_match;
  bit              search_over;
  longint unsigned ptype;
  longint unsigned psize;
  longint unsigned pidx;
  logic [63:0]     cand [4];
  logic [63:0]     kept [4];
  stamp_t          stamp_q [$];

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
    longint unsigned r;
    r = a + b;
    return (r > SUM_MAX) ? SUM_MAX : r;
  endfunction

  function automatic void msg_clear();
    sei_st = SEI_TYPE;
    ptype = 0;
    psize = 0;
    pidx = 0;
  endfunction

  function automatic void clear_all();
    zero_run = 0;
    nal_st = NAL_SEARCH;
    in_sei = 1'b0;
    esc_zeros = 0;
    msg_clear();
    id_match = 1'b1;
    cand = '{default: '0};
    kept = '{default: '0};
    search_over = 1'b0;
  endfunction

  function automatic void sei_byte(logic [7:0] b);
    bit wanted;
    int k;
    case (sei_st)
      SEI_TYPE: begin
        ptype = sat_add(ptype, b);
        if (b != EXT_BYTE) sei_st = SEI_SIZE;
      end
      SEI_SIZE: begin
        psize = sat_add(psize, b);
        if (b != EXT_BYTE) begin
          pidx = 0;
          id_match = 1'b1;
          cand = '{default: '0};
          if (psize >= SUM_MAX) sei_st = SEI_SKIP;
          else if (psize == 0) msg_clear();
          else sei_st = SEI_PAYLOAD;
        end
      end
      SEI_PAYLOAD: begin
        wanted = (ptype == PTYPE_USER_DATA) && (psize >= MIN_PAYLOAD);
        if (wanted) begin
          if (pidx < UUID_LEN) begin
            if (b != MARKER_UUID[pidx]) id_match = 1'b0;
          end else if (pidx >= WORDS_FIRST && pidx < MIN_PAYLOAD) begin
            k = int'(pidx) - WORDS_FIRST;
            cand[k / 8][8 * (k % 8) +: 8] = b;
          end
        end
        pidx++;
        if (pidx >= psize) begin
          if (wanted && id_match) begin
            kept = cand;
            search_over = 1'b1;
          end
          msg_clear();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void nal_byte(logic [7:0] b);
    if (search_over) return;
    if (nal_st == NAL_HEADER) begin
      in_sei = (b[4:0] & NAL_TYPE_MASK) == NAL_TYPE_SEI;
      nal_st = NAL_BODY;
      esc_zeros = 0;
      msg_clear();
      return;
    end
    if (nal_st != NAL_BODY || !in_sei) return;
    if (esc_zeros == 2 && b == ESC_BYTE) begin
      esc_zeros = 0;
      return;
    end
    if (b == 8'h00) esc_zeros = (esc_zeros < 3) ? esc_zeros + 1 : 3;
    else esc_zeros = 0;
    sei_byte(b);
  endfunction

  function automatic void release_zeros();
    while (zero_run > 0) begin
      nal_byte(8'h00);
      zero_run--;
    end
  endfunction

  function automatic void take_byte(logic [7:0] b, logic last);
    stamp_t s;
    if (b == 8'h00) begin
      if (zero_run >= 3) nal_byte(8'h00);
      else zero_run++;
    end else if (b == START_BYTE && zero_run >= 2) begin
      zero_run = 0;
      nal_st = NAL_HEADER;
      in_sei = 1'b0;
    end else begin
      release_zeros();
      nal_byte(b);
    end
    if (last) begin
      release_zeros();
      s.found = search_over && kept[1] != 0 && kept[2] != 0 && kept[3] != 0;
      s.marker_seen = search_over;
      s.frame_id = search_over ? kept[0] : '0;
      s.capture_ms = search_over ? kept[1] : '0;
      s.encode_ms = search_over ? kept[2] : '0;
      s.send_ms = search_over ? kept[3] : '0;
      stamp_q.push_back(s);
      clear_all();
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    stamp_t got_s;
    stamp_t exp_s;
    if (rst) begin
      clear_all();
      stamp_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got_s = m_tdata[OUT_BITS-1:0];
        if (stamp_q.size() == 0) begin
          $error("result item with no expected result waiting");
          mismatches++;
        end else begin
          exp_s = stamp_q.pop_front();
          check_field("found", exp_s.found, got_s.found);
          check_field("marker_seen", exp_s.marker_seen, got_s.marker_seen);
          check_field("frame_id", exp_s.frame_id, got_s.frame_id);
          check_field("capture_ms", exp_s.capture_ms, got_s.capture_ms);
          check_field("encode_ms", exp_s.encode_ms, got_s.encode_ms);
          check_field("send_ms", exp_s.send_ms, got_s.send_ms);
          check_field("pad", '0, m_tdata[OUT_W-1:OUT_BITS]);
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
    end
    awaiting = stamp_q.size();
  end

endmodule

// ===== verif/tb_annexb_sei_timestamp_extractor.sv =====
// Testbench top for the Annex B SEI timestamp extractor: byte stimulus and verdict.
module tb_annexb_sei_timestamp_extractor;
  import ase_pkg::*;

  localparam int SIZE_BITS = 16;
  localparam int SUM_LIMIT = (1 << SIZE_BITS) - 1;
  localparam int HOLD_AT = 20;
  localparam int HOLD_CYCLES = 2000;
  localparam int RANDOM_BYTES = 1500;
  localparam int RANDOM_FRAMES = 48;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;   // data_byte
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;           // found, marker_seen, frame_id, capture_ms,
                                       // encode_ms, send_ms
  int mismatches;
  int awaiting;

  logic [7:0] frame_q [$];
  logic [7:0] rbsp_q [$];
  int bytes_sent;
  int frames_sent;
  bit send_calm;
  bit sink_calm;

  always #10 clk = ~clk;

  annexb_sei_timestamp_extractor #(.SIZE_BITS(SIZE_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  annexb_sei_timestamp_checker #(.SIZE_BITS(SIZE_BITS)) stamp_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  function automatic void put_count(int v);
    while (v >= 255) begin
      rbsp_q.push_back(EXT_BYTE);
      v -= 255;
    end
    rbsp_q.push_back(8'(v));
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      2: for (int i = 0; i < 8; i++) if ($urandom_range(0, 2) == 0) w[8 * i +: 8] = 8'h00;
      3: w = 64'($urandom_range(0, 3));
      default: ;
    endcase
    return w;
  endfunction

  function automatic void put_marker(int size, bit bad_id, logic [63:0] words [4]);
    int base;
    int k;
    put_count(PTYPE_USER_DATA);
    put_count(size);
    base = rbsp_q.size();
    for (int i = 0; i < size; i++) begin
      if (i < UUID_LEN) begin
        rbsp_q.push_back(MARKER_UUID[i]);
      end else if (i >= WORDS_FIRST && i < MIN_PAYLOAD) begin
        k = i - WORDS_FIRST;
        rbsp_q.push_back(words[k / 8][8 * (k % 8) +: 8]);
      end else begin
        rbsp_q.push_back(8'($urandom()));
      end
    end
    if (bad_id && size >= UUID_LEN) begin
      k = base + $urandom_range(0, UUID_LEN - 1);
      rbsp_q[k] = rbsp_q[k] ^ 8'(1 << $urandom_range(0, 7));
    end
  endfunction

  function automatic void put_message(int ptype, int size);
    put_count(ptype);
    put_count(size);
    repeat (size) rbsp_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom()));
  endfunction

  function automatic void put_start(int len);
    repeat (len - 1) frame_q.push_back(8'h00);
    frame_q.push_back(START_BYTE);
  endfunction

  // start code, header, then the payload with emulation prevention inserted
  function automatic void emit_nal(logic [7:0] hdr, int len, int cut);
    int zeros;
    zeros = 0;
    put_start(len);
    frame_q.push_back(hdr);
    repeat (cut) if (rbsp_q.size() > 0) void'(rbsp_q.pop_back());
    foreach (rbsp_q[i]) begin
      if (zeros >= 2 && rbsp_q[i] <= ESC_BYTE) begin
        frame_q.push_back(ESC_BYTE);
        zeros = 0;
      end
      frame_q.push_back(rbsp_q[i]);
      zeros = (rbsp_q[i] == 8'h00) ? zeros + 1 : 0;
    end
    rbsp_q.delete();
  endfunction

  function automatic logic [7:0] sei_hdr();
    logic [7:0] h;
    h = 8'($urandom());
    h[4:0] = NAL_TYPE_SEI;
    return h;
  endfunction

  function automatic logic [7:0] other_hdr();
    logic [7:0] h;
    h = 8'($urandom());
    if (h[4:0] == NAL_TYPE_SEI) h[0] = ~h[0];
    return h;
  endfunction

  function automatic int pick_start_len();
    case ($urandom_range(0, 7))
      0, 1, 2: return 4;
      3: return $urandom_range(5, 7);
      default: return 3;
    endcase
  endfunction

  function automatic void build_random_frame();
    int kind;
    logic [63:0] w [4];
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 40)) begin
        case ($urandom_range(0, 3))
          0, 1: frame_q.push_back(8'h00);
          2: frame_q.push_back(START_BYTE);
          default: frame_q.push_back(8'($urandom()));
        endcase
      end
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(1, 255)));
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 7) == 0) put_start(pick_start_len());
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(0, 20)) rbsp_q.push_back(8'($urandom()));
        emit_nal(other_hdr(), pick_start_len(), 0);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          kind = $urandom_range(0, 19);
          foreach (w[i]) w[i] = rand_word();
          if (kind < 10) begin
            put_marker(($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(MIN_PAYLOAD, 60),
                       $urandom_range(0, 5) == 0, w);
          end else if (kind < 12) begin
            put_marker($urandom_range(UUID_LEN, MIN_PAYLOAD - 1), 1'b0, w);
          end else if (kind == 12 && $urandom_range(0, 3) == 0) begin
            put_count(PTYPE_USER_DATA);
            put_count(SUM_LIMIT + $urandom_range(0, 300));
            repeat ($urandom_range(0, 10)) rbsp_q.push_back(8'($urandom()));
          end else begin
            put_message($urandom_range(0, 300), $urandom_range(0, 20));
          end
        end
        if ($urandom_range(0, 1) == 0) rbsp_q.push_back(8'h80);
        emit_nal(sei_hdr(), pick_start_len(),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 0);
      end
    end
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) frame_q.push_back(8'h00);
  endfunction

  task automatic send_frame();
    int gap;
    if (frame_q.size() == 0) frame_q.push_back(8'($urandom()));
    foreach (frame_q[i]) begin
      gap = send_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tdata <= frame_q[i];
      s_tlast <= (i == frame_q.size() - 1);
      s_tvalid <= 1'b1;
      do @(posedge clk); while (!s_tready);
      bytes_sent++;
    end
    frame_q.delete();
    frames_sent++;
    if ($urandom_range(0, 3) == 0) send_calm = ~send_calm;
  endtask

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side; one long hold-off lets the input side back up
  initial begin : sink
    int gap;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else gap = sink_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      if ($urandom_range(0, 4) == 0) sink_calm = ~sink_calm;
    end
  end

  initial begin
    logic [63:0] w [4];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single byte buffer
    frame_q.push_back(8'h00);
    send_frame();

    // junk before the first start code, marker with extreme words
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h7E);
    w = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE};
    put_marker(MIN_PAYLOAD, 1'b0, w);
    rbsp_q.push_back(8'h80);
    emit_nal(8'h06, 4, 0);
    send_frame();

    // capture time zero: seen but not found
    w = '{64'h1234, 64'h0, 64'h55, 64'h66};
    put_marker(MIN_PAYLOAD + 3, 1'b0, w);
    emit_nal(sei_hdr(), 3, 0);
    send_frame();

    // corrupted identifier
    foreach (w[i]) w[i] = rand_word();
    put_marker(MIN_PAYLOAD, 1'b1, w);
    emit_nal(sei_hdr(), 4, 0);
    send_frame();

    // words full of zeros force escape bytes; trailing zeros end the buffer
    w = '{64'h0000_0000_0000_0001, 64'h0000_0300_0000_0002, 64'h0000_0000_0003_0000,
          64'h0100_0000_0000_0000};
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(8'h06, 3, 0);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    send_frame();

    // payload too short, zero size and ff-extended other types
    foreach (w[i]) w[i] = rand_word();
    put_marker(MIN_PAYLOAD - 1, 1'b0, w);
    put_message(4, 0);
    put_message(300, 7);
    emit_nal(sei_hdr(), 3, 0);
    send_frame();

    // marker cut short by the next start code, then a full one
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 3, 5);
    foreach (w[i]) w[i] = rand_word();
    put_marker(MIN_PAYLOAD + 1, 1'b0, w);
    emit_nal(sei_hdr(), 4, 0);
    send_frame();

    // size just below saturation, saturated size, then a marker in a fresh NAL
    put_count(PTYPE_USER_DATA);
    put_count(SUM_LIMIT - 1);
    repeat (20) rbsp_q.push_back(8'($urandom()));
    emit_nal(sei_hdr(), 3, 0);
    put_count(PTYPE_USER_DATA);
    put_count(SUM_LIMIT);
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 3, 0);
    w = '{64'hA, 64'hB, 64'hC, 64'hD};
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 3, 0);
    send_frame();

    // saturated type sum, then a marker in the same NAL
    put_count(SUM_LIMIT + 10);
    put_message(1, 3);
    foreach (w[i]) w[i] = rand_word();
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 3, 0);
    send_frame();

    // empty NAL before the marker
    put_start(4);
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 3, 0);
    send_frame();

    // start code on the last byte
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 3, 0);
    put_start(3);
    send_frame();

    // second marker after the search has ended is ignored
    w = '{64'h11, 64'h22, 64'h33, 64'h44};
    put_marker(MIN_PAYLOAD, 1'b0, w);
    w = '{64'h99, 64'h88, 64'h77, 64'h66};
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 4, 0);
    send_frame();

    // marker inside a non-SEI NAL
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(8'h65, 4, 0);
    send_frame();

    // extra zeros ahead of the start code
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 7, 0);
    send_frame();

    // zero-size message then an ff-extended marker size
    put_message(PTYPE_USER_DATA, 0);
    foreach (w[i]) w[i] = rand_word();
    put_marker(265, 1'b0, w);
    emit_nal(sei_hdr(), 3, 0);
    send_frame();

    // payload incomplete at the buffer end
    put_marker(MIN_PAYLOAD, 1'b0, w);
    emit_nal(sei_hdr(), 3, 1);
    send_frame();

    // payload completed by zeros held on the last byte
    put_marker(52, 1'b0, w);
    rbsp_q[rbsp_q.size() - 1] = 8'h00;
    rbsp_q[rbsp_q.size() - 2] = 8'h00;
    emit_nal(sei_hdr(), 3, 0);
    send_frame();

    // sender pause until all results are back
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (awaiting == 0);

    bytes_sent = 0;
    frames_sent = 0;
    while (bytes_sent < RANDOM_BYTES || frames_sent < RANDOM_FRAMES) begin
      build_random_frame();
      send_frame();
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (awaiting == 0);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ase_pkg.sv
rtl/annexb_sei_timestamp_extractor.sv
rtl/ase_checker.sv
verif/annexb_sei_timestamp_checker.sv
verif/tb_annexb_sei_timestamp_extractor.sv
